@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge.
`define ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/mpsh_pkg.sv @@
// ----------------------------------------------------------------------------
// mpsh_pkg
// Types and constants of the multi-position selector with hysteresis.
// ----------------------------------------------------------------------------
package mpsh_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int POS_W      = 6;
	localparam int COUNT_W    = 7;
	localparam int FRAC_W     = 9;
	localparam int WIDTH_W    = 17;
	localparam int MUL_B_W    = 9;
	localparam int ACC_W      = 27;
	localparam int IDX_W      = 7;
	localparam int FRAC_SHIFT = 8;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;
	localparam int S_TDATA_W  = 16;
	localparam int M_TDATA_W  = 8;

	localparam logic [COUNT_W-1:0] MAX_POSITIONS = 7'd64;
	localparam logic [FRAC_W-1:0]  FRAC_FULL     = 9'd256;

	localparam logic [SAMPLE_W-1:0] RANGE_LOW_RST  = 16'd0;
	localparam logic [SAMPLE_W-1:0] RANGE_HIGH_RST = 16'd1023;
	localparam logic [COUNT_W-1:0]  COUNT_RST      = 7'd4;
	localparam logic [FRAC_W-1:0]   FRAC_RST       = 9'd51;

	localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT      = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DEADZONE   = 8'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_START,
		ST_GAP_WAIT,
		ST_MUL_GAP,
		ST_GAP_STORE,
		ST_BAND_START,
		ST_BAND_WAIT,
		ST_CHECK,
		ST_EDGE_BW,
		ST_EDGE_GW,
		ST_EDGE_TEST,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic en;
		logic load;
		logic sub;
	} mac_op_t;

endpackage

@@ design/multi_position_selector_hysteresis.sv @@
// ----------------------------------------------------------------------------
// multi_position_selector_hysteresis
// Maps each sample onto one of up to 64 selector positions with hysteresis.
// ----------------------------------------------------------------------------
// Each accepted sample gives one position. A sample that stays within the
// edges of the current band is resolved without a scan. When it leaves
// them, the band edges are worked out on one shared multiply-accumulate
// unit, position by position, and then the other edge of the band found.
// The first sample after reset or a configuration write first recomputes
// the band and deadzone widths on a serial divider of one bit per cycle,
// and then scans from the bottom. The block takes no sample while one is
// at work; a result waits in the output register and the next sample may
// be taken meanwhile. Configuration writes are always accepted out of
// reset and must only be made while the block is idle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module multi_position_selector_hysteresis (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// s_tdata: sample [15:0]
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [mpsh_pkg::S_TDATA_W-1:0]       s_tdata,
	// m_tdata: position [5:0], zero [7:6]
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [mpsh_pkg::M_TDATA_W-1:0]       m_tdata,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [mpsh_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [mpsh_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int SW    = mpsh_pkg::SAMPLE_W;
	localparam int WW    = mpsh_pkg::WIDTH_W;
	localparam int AW    = mpsh_pkg::ACC_W;
	localparam int CW    = mpsh_pkg::COUNT_W;
	localparam int IW    = mpsh_pkg::IDX_W;
	localparam int PW    = mpsh_pkg::POS_W;
	localparam int BW    = mpsh_pkg::MUL_B_W;
	localparam int SHIFT = mpsh_pkg::FRAC_SHIFT;

	mpsh_pkg::state_t state_q, state_d;

	logic signed [SW-1:0]        range_low_q, range_high_q;
	logic [CW-1:0]               count_q;
	logic [mpsh_pkg::FRAC_W-1:0] frac_q;
	logic                        needs_q;

	logic signed [SW-1:0] s_q, ble_q, bhe_q;
	logic [PW-1:0]        cur_q, out_pos_q;
	logic [IW-1:0]        idx_q;
	logic                 dir_up_q, fetch_q, rel_q;
	logic [WW-1:0]        band_q, gap_q;
	logic                 m_tvalid_q;

	logic signed [SW-1:0]        lo_w, hi_w, s_in, s_clamp, edge_w;
	logic [CW-1:0]               n_eff, gaps_w;
	logic [mpsh_pkg::FRAC_W-1:0] frac_eff;
	logic [WW-1:0]               total_w, budget_w, gap_new;
	logic signed [AW-1:0]        lo_ext, hi_ext, acc_w;
	logic                        edge_upper, s_above, s_below, out_free, go_up;
	logic [IW-1:0]               idx_inc, idx_dec, b_bw, b_gw, up_start;

	mpsh_pkg::mac_op_t    mac_op;
	logic signed [AW-1:0] mac_base;
	logic [WW-1:0]        mac_a;
	logic [BW-1:0]        mac_b;

	logic          div_start, div_busy, div_done;
	logic [WW-1:0] div_dividend, div_quot;
	logic [CW-1:0] div_divisor;

	// Configuration derived values
	always_comb begin
		if (range_low_q < range_high_q) begin
			lo_w = range_low_q;
			hi_w = range_high_q;
		end else begin
			lo_w = range_high_q;
			hi_w = range_low_q;
		end
		if (count_q == '0) begin
			n_eff = CW'(1);
		end else if (count_q > mpsh_pkg::MAX_POSITIONS) begin
			n_eff = mpsh_pkg::MAX_POSITIONS;
		end else begin
			n_eff = count_q;
		end
		frac_eff = (frac_q > mpsh_pkg::FRAC_FULL) ? mpsh_pkg::FRAC_FULL : frac_q;
	end

	assign gaps_w   = n_eff - CW'(1);
	assign total_w  = {hi_w[SW-1], hi_w} - {lo_w[SW-1], lo_w};
	assign budget_w = (total_w > {{(WW - CW){1'b0}}, n_eff}) ?
		(total_w - {{(WW - CW){1'b0}}, n_eff}) : '0;
	assign lo_ext   = {{(AW - SW){lo_w[SW-1]}}, lo_w};
	assign hi_ext   = {{(AW - SW){hi_w[SW-1]}}, hi_w};
	assign gap_new  = acc_w[SHIFT +: WW];

	assign s_in    = signed'(s_tdata[SW-1:0]);
	assign s_clamp = (s_in < lo_w) ? lo_w : ((s_in > hi_w) ? hi_w : s_in);

	assign edge_w = (acc_w < lo_ext) ? lo_w : ((acc_w > hi_ext) ? hi_w : acc_w[SW-1:0]);

	assign edge_upper = dir_up_q ^ fetch_q;
	assign idx_inc    = idx_q + IW'(1);
	assign idx_dec    = idx_q - IW'(1);
	assign b_bw       = edge_upper ? idx_inc : idx_q;
	assign b_gw       = edge_upper ? idx_inc : ((idx_q != '0) ? idx_dec : '0);
	assign s_above    = s_q > edge_w;
	assign s_below    = s_q < edge_w;
	assign out_free   = !m_tvalid_q || m_tready;
	assign go_up      = !rel_q || (s_q > bhe_q);
	assign up_start   = rel_q ? {1'b0, cur_q} : '0;

	mpsh_mac u_mac (
		.clk   (clk),
		.op    (mac_op),
		.base  (mac_base),
		.mul_a (mac_a),
		.mul_b (mac_b),
		.acc   (acc_w)
	);

	mpsh_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mpsh_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		mac_op       = '0;
		mac_base     = '0;
		mac_a        = '0;
		mac_b        = '0;
		div_start    = 1'b0;
		div_dividend = budget_w;
		div_divisor  = gaps_w;
		unique case (state_q)
			mpsh_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					state_d = needs_q ? mpsh_pkg::ST_START : mpsh_pkg::ST_CHECK;
				end
			end
			mpsh_pkg::ST_START: begin
				div_start = n_eff > CW'(1);
				state_d   = mpsh_pkg::ST_GAP_WAIT;
			end
			mpsh_pkg::ST_GAP_WAIT: begin
				if ((n_eff == CW'(1)) || div_done) begin
					state_d = mpsh_pkg::ST_MUL_GAP;
				end
			end
			mpsh_pkg::ST_MUL_GAP: begin
				mac_op  = '{en: 1'b1, load: 1'b1, sub: 1'b0};
				mac_a   = (n_eff > CW'(1)) ? div_quot : '0;
				mac_b   = frac_eff;
				state_d = mpsh_pkg::ST_GAP_STORE;
			end
			mpsh_pkg::ST_GAP_STORE: begin
				mac_op   = '{en: 1'b1, load: 1'b1, sub: 1'b1};
				mac_base = {{(AW - WW){1'b0}}, total_w};
				mac_a    = gap_new;
				mac_b    = {{(BW - CW){1'b0}}, gaps_w};
				state_d  = mpsh_pkg::ST_BAND_START;
			end
			mpsh_pkg::ST_BAND_START: begin
				div_start    = 1'b1;
				div_dividend = acc_w[WW-1:0];
				div_divisor  = n_eff;
				state_d      = mpsh_pkg::ST_BAND_WAIT;
			end
			mpsh_pkg::ST_BAND_WAIT: begin
				if (div_done) begin
					state_d = mpsh_pkg::ST_CHECK;
				end
			end
			mpsh_pkg::ST_CHECK: begin
				if (go_up) begin
					state_d = (up_start >= n_eff) ? mpsh_pkg::ST_DONE : mpsh_pkg::ST_EDGE_BW;
				end else if (s_q < ble_q) begin
					state_d = mpsh_pkg::ST_EDGE_BW;
				end else begin
					state_d = mpsh_pkg::ST_DONE;
				end
			end
			mpsh_pkg::ST_EDGE_BW: begin
				mac_op   = '{en: 1'b1, load: 1'b1, sub: 1'b0};
				mac_base = lo_ext;
				mac_a    = band_q;
				mac_b    = {{(BW - IW){1'b0}}, b_bw};
				state_d  = mpsh_pkg::ST_EDGE_GW;
			end
			mpsh_pkg::ST_EDGE_GW: begin
				mac_op  = '{en: 1'b1, load: 1'b0, sub: 1'b0};
				mac_a   = gap_q;
				mac_b   = {{(BW - IW){1'b0}}, b_gw};
				state_d = mpsh_pkg::ST_EDGE_TEST;
			end
			mpsh_pkg::ST_EDGE_TEST: begin
				state_d = mpsh_pkg::ST_EDGE_BW;
				if (fetch_q) begin
					state_d = mpsh_pkg::ST_DONE;
				end else if (dir_up_q) begin
					if (s_above && (idx_inc >= n_eff)) begin
						state_d = mpsh_pkg::ST_DONE;
					end
				end else if (s_below && (idx_q == '0)) begin
					state_d = mpsh_pkg::ST_DONE;
				end
			end
			mpsh_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = mpsh_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mpsh_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_low_q  <= signed'(mpsh_pkg::RANGE_LOW_RST);
			range_high_q <= signed'(mpsh_pkg::RANGE_HIGH_RST);
			count_q      <= mpsh_pkg::COUNT_RST;
			frac_q       <= mpsh_pkg::FRAC_RST;
			needs_q      <= 1'b1;
			cur_q        <= '0;
			ble_q        <= '0;
			bhe_q        <= '0;
			band_q       <= '0;
			gap_q        <= '0;
			idx_q        <= '0;
			dir_up_q     <= 1'b0;
			fetch_q      <= 1'b0;
			rel_q        <= 1'b0;
			m_tvalid_q   <= 1'b0;
		end else begin
			case (state_q)
				mpsh_pkg::ST_IDLE: begin
					if (s_tvalid) begin
						rel_q <= !needs_q;
					end
				end
				mpsh_pkg::ST_GAP_STORE: begin
					gap_q <= gap_new;
				end
				mpsh_pkg::ST_BAND_WAIT: begin
					if (div_done) begin
						band_q <= div_quot;
					end
				end
				mpsh_pkg::ST_CHECK: begin
					fetch_q <= 1'b0;
					if (go_up) begin
						dir_up_q <= 1'b1;
						idx_q    <= up_start;
					end else begin
						dir_up_q <= 1'b0;
						idx_q    <= {1'b0, cur_q};
					end
				end
				mpsh_pkg::ST_EDGE_TEST: begin
					if (fetch_q) begin
						if (dir_up_q) begin
							ble_q <= edge_w;
						end else begin
							bhe_q <= edge_w;
						end
					end else if (dir_up_q) begin
						if (s_above) begin
							idx_q <= idx_inc;
						end else begin
							cur_q   <= idx_q[PW-1:0];
							bhe_q   <= edge_w;
							fetch_q <= 1'b1;
						end
					end else begin
						if (s_below) begin
							if (idx_q != '0) begin
								idx_q <= idx_dec;
							end
						end else begin
							cur_q   <= idx_q[PW-1:0];
							ble_q   <= edge_w;
							fetch_q <= 1'b1;
						end
					end
				end
				default: begin
				end
			endcase

			if ((state_q == mpsh_pkg::ST_DONE) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			if (cfg_valid && (cfg_index <= mpsh_pkg::REG_DEADZONE)) begin
				needs_q <= 1'b1;
			end else if ((state_q == mpsh_pkg::ST_BAND_WAIT) && div_done) begin
				needs_q <= 1'b0;
			end

			if (cfg_valid) begin
				unique case (cfg_index)
					mpsh_pkg::REG_RANGE_LOW: begin
						range_low_q <= signed'(cfg_data[SW-1:0]);
					end
					mpsh_pkg::REG_RANGE_HIGH: begin
						range_high_q <= signed'(cfg_data[SW-1:0]);
					end
					mpsh_pkg::REG_COUNT: begin
						count_q <= cfg_data[CW-1:0];
					end
					mpsh_pkg::REG_DEADZONE: begin
						frac_q <= cfg_data[mpsh_pkg::FRAC_W-1:0];
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == mpsh_pkg::ST_IDLE) && s_tvalid) begin
			s_q <= s_clamp;
		end
		if ((state_q == mpsh_pkg::ST_DONE) && out_free) begin
			out_pos_q <= cur_q;
		end
	end

	assign s_tready  = arst_n && (state_q == mpsh_pkg::ST_IDLE);
	assign cfg_ready = arst_n;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = {{(mpsh_pkg::M_TDATA_W - PW){1'b0}}, out_pos_q};

	`ASSERT_IMPLY(a_div_start_idle, div_start, !div_busy, "divider started while busy")
	`ASSERT_IMPLY(a_scan_widths_ready, state_q == mpsh_pkg::ST_EDGE_BW, !needs_q,
		"scan before widths recomputed")
	`ASSERT_IMPLY(a_up_index_in_range,
		(state_q == mpsh_pkg::ST_EDGE_BW) && dir_up_q && !fetch_q, idx_q < n_eff,
		"upward scan index beyond count")
	`ASSERT_IMPLY(a_sample_clamped, state_q == mpsh_pkg::ST_EDGE_TEST,
		(s_q >= lo_w) && (s_q <= hi_w), "held sample outside range")
	`ASSERT_NEXT(a_result_loaded, (state_q == mpsh_pkg::ST_DONE) && out_free, m_tvalid_q,
		"finished result not presented")

endmodule

@@ design/mpsh_div.sv @@
// ----------------------------------------------------------------------------
// mpsh_div
// Serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mpsh_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [mpsh_pkg::WIDTH_W-1:0]       dividend,
	input  logic [mpsh_pkg::COUNT_W-1:0]       divisor,
	output logic                               busy,
	output logic                               done,
	output logic [mpsh_pkg::WIDTH_W-1:0]       quotient
);

	localparam int CNT_W = $clog2(mpsh_pkg::WIDTH_W);

	logic [mpsh_pkg::WIDTH_W-1:0] quo_q;
	logic [mpsh_pkg::COUNT_W-1:0] rem_q;
	logic [mpsh_pkg::COUNT_W-1:0] div_q;
	logic [CNT_W-1:0]             cnt_q;
	logic                         busy_q;
	logic                         done_q;
	logic [mpsh_pkg::COUNT_W:0]   rem_sh;
	logic                         ge;
	logic [mpsh_pkg::COUNT_W:0]   rem_sub;

	assign rem_sh  = {rem_q, quo_q[mpsh_pkg::WIDTH_W-1]};
	assign ge      = rem_sh >= {1'b0, div_q};
	assign rem_sub = rem_sh - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(mpsh_pkg::WIDTH_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[mpsh_pkg::WIDTH_W-2:0], ge};
			rem_q <= ge ? rem_sub[mpsh_pkg::COUNT_W-1:0] : rem_sh[mpsh_pkg::COUNT_W-1:0];
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

@@ design/mpsh_mac.sv @@
// ----------------------------------------------------------------------------
// mpsh_mac
// Shared multiply-accumulate unit used for the widths and the band edges.
// ----------------------------------------------------------------------------
module mpsh_mac (
	input  logic                                clk,
	input  mpsh_pkg::mac_op_t                   op,
	input  logic signed [mpsh_pkg::ACC_W-1:0]   base,
	input  logic [mpsh_pkg::WIDTH_W-1:0]        mul_a,
	input  logic [mpsh_pkg::MUL_B_W-1:0]        mul_b,
	output logic signed [mpsh_pkg::ACC_W-1:0]   acc
);

	localparam int PROD_W = mpsh_pkg::WIDTH_W + mpsh_pkg::MUL_B_W;

	logic [PROD_W-1:0]                 prod;
	logic signed [mpsh_pkg::ACC_W-1:0] term;
	logic signed [mpsh_pkg::ACC_W-1:0] start_val;
	logic signed [mpsh_pkg::ACC_W-1:0] acc_q;

	assign prod      = mul_a * mul_b;
	assign term      = signed'({{(mpsh_pkg::ACC_W - PROD_W){1'b0}}, prod});
	assign start_val = op.load ? base : acc_q;

	always_ff @(posedge clk) begin
		if (op.en) begin
			acc_q <= op.sub ? (start_val - term) : (start_val + term);
		end
	end

	assign acc = acc_q;

endmodule
